@@ sv/lseg_pkg.sv @@
package lseg_pkg;

  localparam int unsigned START_W = 12;
  localparam int unsigned END_W   = 13;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned TOTAL_W = 12;
  localparam int unsigned DIM_W   = 13;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic               has_seg;
    logic               has_sum;
    logic [START_W-1:0] start_row;
    logic [END_W-1:0]   end_row;
    logic [INDEX_W-1:0] line_index;
    logic [TOTAL_W-1:0] line_total;
  } lseg_evt_t;

endpackage

@@ sv/lseg_front.sv @@
module lseg_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_pixel_ink,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [lseg_pkg::DIM_W-1:0] cfg_data,
  input  logic                       fifo_full,
  output logic                       push,
  output lseg_pkg::lseg_evt_t        push_evt
);
  import lseg_pkg::*;

  localparam int unsigned PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned SW = $clog2((MAX_DIM + 1) / 2 + 1);

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [DW-1:0] width_r, height_r;
  logic [PW-1:0] col_r, row_r, seg_start_r;
  logic [PW-1:0] col_nxt, row_nxt, seg_start_nxt;
  logic          seen_r, inside_r, seen_nxt, inside_nxt;
  logic [SW-1:0] found_r, found_nxt;

  logic          accept, ink_any, row_end, frame_end, seg_close, has_seg;
  logic [PW:0]   col_inc, row_inc;
  logic [PW-1:0] start_cur;
  logic [SW:0]   total;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    ink_any   = seen_r || in_pixel_ink;
    col_inc   = {1'b0, col_r} + 1'b1;
    row_inc   = {1'b0, row_r} + 1'b1;
    row_end   = col_inc >= (PW + 1)'(width_r);
    frame_end = row_inc >= (PW + 1)'(height_r);
    seg_close = !ink_any && inside_r;
    start_cur = (ink_any && !inside_r) ? row_r : seg_start_r;
    has_seg   = seg_close || (frame_end && ink_any);
    total     = {1'b0, found_r} + (SW + 1)'(has_seg);

    push_evt.has_seg    = has_seg;
    push_evt.has_sum    = frame_end;
    push_evt.start_row  = START_W'(start_cur);
    push_evt.end_row    = seg_close ? END_W'(row_r) : END_W'(row_inc);
    push_evt.line_index = INDEX_W'(found_r);
    push_evt.line_total = TOTAL_W'(total);
    push = accept && row_end && (has_seg || frame_end);

    col_nxt       = col_r;
    row_nxt       = row_r;
    seen_nxt      = seen_r;
    inside_nxt    = inside_r;
    seg_start_nxt = seg_start_r;
    found_nxt     = found_r;
    if (accept) begin
      if (!row_end) begin
        col_nxt  = col_inc[PW-1:0];
        seen_nxt = ink_any;
      end else begin
        col_nxt  = '0;
        seen_nxt = 1'b0;
        if (frame_end) begin
          row_nxt       = '0;
          inside_nxt    = 1'b0;
          seg_start_nxt = '0;
          found_nxt     = '0;
        end else begin
          row_nxt       = row_inc[PW-1:0];
          inside_nxt    = ink_any;
          seg_start_nxt = start_cur;
          found_nxt     = found_r + SW'(seg_close);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DW'(1);
      height_r    <= DW'(1);
      col_r       <= '0;
      row_r       <= '0;
      seen_r      <= 1'b0;
      inside_r    <= 1'b0;
      seg_start_r <= '0;
      found_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= clamp_dim(cfg_data);
          REG_IMAGE_HEIGHT: height_r <= clamp_dim(cfg_data);
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      seen_r      <= seen_nxt;
      inside_r    <= inside_nxt;
      seg_start_r <= seg_start_nxt;
      found_r     <= found_nxt;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("event pushed into a full queue");

endmodule

@@ sv/lseg_fifo.sv @@
module lseg_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lseg_pkg::lseg_evt_t push_evt,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output lseg_pkg::lseg_evt_t head_evt
);
  import lseg_pkg::*;

  lseg_evt_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full       = cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_evt   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

@@ sv/lseg_back.sv @@
module lseg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  lseg_pkg::lseg_evt_t          head_evt,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_record_kind,
  output logic [lseg_pkg::START_W-1:0] out_start_row,
  output logic [lseg_pkg::END_W-1:0]   out_end_row,
  output logic [lseg_pkg::INDEX_W-1:0] out_line_index,
  output logic [lseg_pkg::TOTAL_W-1:0] out_line_total,
  output logic                         out_last_of_run
);
  import lseg_pkg::*;

  logic               valid_r, phase_r, load, emit_seg;
  logic               kind_r, last_r;
  logic [START_W-1:0] start_r;
  logic [END_W-1:0]   end_r;
  logic [INDEX_W-1:0] index_r;
  logic [TOTAL_W-1:0] total_r;

  assign load     = (!valid_r || out_ready) && head_valid;
  assign emit_seg = head_evt.has_seg && !phase_r;
  assign pop      = load && !(emit_seg && head_evt.has_sum);

  assign out_valid       = valid_r;
  assign out_record_kind = kind_r;
  assign out_start_row   = start_r;
  assign out_end_row     = end_r;
  assign out_line_index  = index_r;
  assign out_line_total  = total_r;
  assign out_last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_seg) begin
        kind_r  <= KIND_SEGMENT;
        start_r <= head_evt.start_row;
        end_r   <= head_evt.end_row;
        index_r <= head_evt.line_index;
        total_r <= '0;
        last_r  <= !head_evt.has_sum;
      end else begin
        kind_r  <= KIND_SUMMARY;
        start_r <= '0;
        end_r   <= '0;
        index_r <= '0;
        total_r <= head_evt.line_total;
        last_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        phase_r <= emit_seg && head_evt.has_sum;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_SUMMARY |-> last_r)
    else $error("summary word without last flag");

  a_phase_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> head_valid && head_evt.has_sum)
    else $error("second word pending without a summary at the head");

endmodule

@@ sv/text_line_row_segmenter_core.sv @@
// Channel  Direction  Handshake               Word
// in       input      in_valid / in_ready     in_pixel_ink
// out      output     out_valid / out_ready   record kind, rows, index, total, last
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel is taken every cycle while the four-entry event queue has room.
// A frame end inside an open line gives two words, which leave the output
// register one after the other; the queue absorbs that, so with one-pixel frames of
// ink the input slows to one pixel for every two output words.
// Reset is synchronous; sizes return to one by one.
// Either side may stall without stopping the other until the queue fills.
module text_line_row_segmenter_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_pixel_ink,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_record_kind,
  output logic [lseg_pkg::START_W-1:0] out_start_row,
  output logic [lseg_pkg::END_W-1:0]   out_end_row,
  output logic [lseg_pkg::INDEX_W-1:0] out_line_index,
  output logic [lseg_pkg::TOTAL_W-1:0] out_line_total,
  output logic                         out_last_of_run,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [lseg_pkg::DIM_W-1:0]   cfg_data
);
  import lseg_pkg::*;

  logic      push, fifo_full, pop, head_valid;
  lseg_evt_t push_evt, head_evt;

  lseg_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_ink (in_pixel_ink),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_evt     (push_evt)
  );

  lseg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_evt   (push_evt),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_evt   (head_evt)
  );

  lseg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_evt        (head_evt),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_record_kind (out_record_kind),
    .out_start_row   (out_start_row),
    .out_end_row     (out_end_row),
    .out_line_index  (out_line_index),
    .out_line_total  (out_line_total),
    .out_last_of_run (out_last_of_run)
  );

endmodule
